>>> src/content_type_sniffer_core_assert.svh
// Assertion macros shared by the sniffer RTL.
`ifndef CONTENT_TYPE_SNIFFER_CORE_ASSERT_SVH
`define CONTENT_TYPE_SNIFFER_CORE_ASSERT_SVH
// Implication checked every clock, quiet during reset.
`define CTS_ASSERT_IMP(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) else $error(msg);
// Next-cycle implication, quiet during reset.
`define CTS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`endif

>>> src/cts_pkg.sv
// ----------------------------------------------------------------------------
// cts_pkg
// Shared constants, rule table and helper functions of the content sniffer.
// ----------------------------------------------------------------------------
package cts_pkg;

   localparam int WINDOW_BYTES_DEF = 512;
   localparam int NUM_RULES        = 51;
   localparam int PAT_LEN          = 14;

   localparam logic [5:0] RULE_TEXT   = 6'd51;
   localparam logic [5:0] RULE_NONE   = 6'd52;
   localparam logic [5:0] MEDIA_TEXT  = 6'd6;
   localparam logic [5:0] MEDIA_OCTET = 6'd32;
   localparam int         RULE_MP4    = 38;

   typedef enum logic [1:0] {
      KIND_HTML = 2'd0,
      KIND_REL  = 2'd1,
      KIND_ABS  = 2'd2,
      KIND_MP4  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [3:0]          n;
      logic [5:0]          off;
      logic [5:0]          need;
      logic [13:0]         care;
      logic [5:0]          media;
      logic [PAT_LEN*8-1:0] pat;   // byte j at [8*j +: 8]
   } rule_type;

   // Pack a string of up to 14 chars so that char j lands at byte j.
   function automatic logic [PAT_LEN*8-1:0] pk(input logic [PAT_LEN*8-1:0] s,
                                               input int len);
      logic [PAT_LEN*8-1:0] r;
      r = '0;
      for (int j = 0; j < PAT_LEN; j++) begin
         if (j < len) r[8*j +: 8] = s[8*(len-1-j) +: 8];
      end
      return r;
   endfunction

   function automatic rule_type mk(input kind_type k, input int n, input int off,
                                   input int need, input int care, input int media,
                                   input logic [PAT_LEN*8-1:0] s);
      rule_type r;
      r.kind  = k;
      r.n     = 4'(n);
      r.off   = 6'(off);
      r.need  = 6'(need);
      r.care  = (care == 0) ? '1 : 14'(care);
      r.media = 6'(media);
      r.pat   = pk(s, n);
      return r;
   endfunction

   function automatic rule_type rule_at(input int k);
      rule_type r;
      case (k)
         0:  r = mk(KIND_HTML, 14, 0, 0, 0, 0, "<!DOCTYPE HTML");
         1:  r = mk(KIND_HTML, 5, 0, 0, 0, 0, "<HTML");
         2:  r = mk(KIND_HTML, 5, 0, 0, 0, 0, "<HEAD");
         3:  r = mk(KIND_HTML, 7, 0, 0, 0, 0, "<SCRIPT");
         4:  r = mk(KIND_HTML, 7, 0, 0, 0, 0, "<IFRAME");
         5:  r = mk(KIND_HTML, 3, 0, 0, 0, 0, "<H1");
         6:  r = mk(KIND_HTML, 4, 0, 0, 0, 0, "<DIV");
         7:  r = mk(KIND_HTML, 5, 0, 0, 0, 0, "<FONT");
         8:  r = mk(KIND_HTML, 6, 0, 0, 0, 0, "<TABLE");
         9:  r = mk(KIND_HTML, 2, 0, 0, 0, 0, "<A");
         10: r = mk(KIND_HTML, 6, 0, 0, 0, 0, "<STYLE");
         11: r = mk(KIND_HTML, 6, 0, 0, 0, 0, "<TITLE");
         12: r = mk(KIND_HTML, 2, 0, 0, 0, 0, "<B");
         13: r = mk(KIND_HTML, 5, 0, 0, 0, 0, "<BODY");
         14: r = mk(KIND_HTML, 3, 0, 0, 0, 0, "<BR");
         15: r = mk(KIND_HTML, 2, 0, 0, 0, 0, "<P");
         16: r = mk(KIND_HTML, 4, 0, 0, 0, 0, "<!--");
         17: r = mk(KIND_REL, 5, 0, 0, 0, 1, "<?xml");
         18: r = mk(KIND_ABS, 5, 0, 5, 0, 2, "%PDF-");
         19: r = mk(KIND_ABS, 11, 0, 11, 0, 3, {"%!PS-A", 8'h64, "obe-"});
         20: r = mk(KIND_ABS, 2, 0, 4, 0, 4, 16'hFEFF);
         21: r = mk(KIND_ABS, 2, 0, 4, 0, 5, 16'hFFFE);
         22: r = mk(KIND_ABS, 3, 0, 4, 0, 6, 24'hEFBBBF);
         23: r = mk(KIND_ABS, 4, 0, 4, 0, 7, 32'h00000100);
         24: r = mk(KIND_ABS, 4, 0, 4, 0, 7, 32'h00000200);
         25: r = mk(KIND_ABS, 2, 0, 2, 0, 8, "BM");
         26: r = mk(KIND_ABS, 6, 0, 6, 0, 9, "GIF87a");
         27: r = mk(KIND_ABS, 6, 0, 6, 0, 9, "GIF89a");
         28: r = mk(KIND_ABS, 14, 0, 14, 'h3F0F, 10, {"RIFF", 32'h0, "WEBPVP"});
         29: r = mk(KIND_ABS, 8, 0, 8, 0, 11, 64'h89504E470D0A1A0A);
         30: r = mk(KIND_ABS, 3, 0, 3, 0, 12, 24'hFFD8FF);
         31: r = mk(KIND_ABS, 4, 0, 4, 0, 13, ".snd");
         32: r = mk(KIND_ABS, 12, 0, 12, 'h0F0F, 14, {"FORM", 32'h0, "AIFF"});
         33: r = mk(KIND_ABS, 3, 0, 3, 0, 15, "ID3");
         34: r = mk(KIND_ABS, 5, 0, 5, 0, 16, {"OggS", 8'h00});
         35: r = mk(KIND_ABS, 8, 0, 8, 0, 17, {"MThd", 32'h00000006});
         36: r = mk(KIND_ABS, 12, 0, 12, 'h0F0F, 18, {"RIFF", 32'h0, "AVI "});
         37: r = mk(KIND_ABS, 12, 0, 12, 'h0F0F, 19, {"RIFF", 32'h0, "WAVE"});
         38: r = mk(KIND_MP4, 0, 0, 12, 0, 20, '0);
         39: r = mk(KIND_ABS, 4, 0, 4, 0, 21, 32'h1A45DFA3);
         40: r = mk(KIND_ABS, 2, 34, 36, 0, 22, "LP");
         41: r = mk(KIND_ABS, 4, 0, 4, 0, 23, 32'h00010000);
         42: r = mk(KIND_ABS, 4, 0, 4, 0, 24, "OTTO");
         43: r = mk(KIND_ABS, 4, 0, 4, 0, 25, "ttcf");
         44: r = mk(KIND_ABS, 4, 0, 4, 0, 26, "wOFF");
         45: r = mk(KIND_ABS, 4, 0, 4, 0, 27, "wOF2");
         46: r = mk(KIND_ABS, 3, 0, 3, 0, 28, 24'h1F8B08);
         47: r = mk(KIND_ABS, 4, 0, 4, 0, 29, {"PK", 16'h0304});
         48: r = mk(KIND_ABS, 7, 0, 7, 0, 30, {"Rar!", 24'h1A0700});
         49: r = mk(KIND_ABS, 8, 0, 8, 0, 30, {"Rar!", 32'h1A070100});
         50: r = mk(KIND_ABS, 4, 0, 4, 0, 31, {8'h00, "asm"});
         default: r = mk(KIND_ABS, 0, 0, 0, 0, 32, '0);
      endcase
      return r;
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h09) || (b == 8'h0A) || (b == 8'h0C) || (b == 8'h0D) ||
             (b == 8'h20);
   endfunction

   function automatic logic is_control(input logic [7:0] b);
      return (b <= 8'h08) || (b == 8'h0B) || (b >= 8'h0E && b <= 8'h1A) ||
             (b >= 8'h1C && b <= 8'h1F);
   endfunction

   // Control inputs of the per-rule kill decision for one byte.
   typedef struct packed {
      logic        take;
      logic        lead;     // still in leading whitespace after this byte
      logic [7:0]  b;
   } byte_ctl_type;

endpackage

>>> src/cts_match.sv
// ----------------------------------------------------------------------------
// cts_match
// Per-byte rule update: kill mask for the signature rules from one byte.
// ----------------------------------------------------------------------------
module cts_match
   import cts_pkg::*;
#(
   parameter int PW = 10
) (
   input  byte_ctl_type           ctl,
   input  logic [PW-1:0]          pos,
   input  logic [PW-1:0]          rel,
   output logic [NUM_RULES-1:0]   kill
);

   always_comb begin
      rule_type   s;
      logic [7:0] c;
      logic [7:0] d;
      logic [PW-1:0] j;
      kill = '0;
      for (int k = 0; k < NUM_RULES; k++) begin
         s = rule_at(k);
         c = 8'h00;
         d = ctl.b;
         j = '0;
         if (ctl.take) begin
            case (s.kind)
               KIND_HTML: begin
                  if (!ctl.lead) begin
                     if (rel < PW'(s.n)) begin
                        c = s.pat[8*rel[3:0] +: 8];
                        if (c >= "A" && c <= "Z") d = ctl.b & 8'hDF;
                        kill[k] = (d != c);
                     end else if (rel == PW'(s.n)) begin
                        kill[k] = (ctl.b != " ") && (ctl.b != ">");
                     end
                  end
               end
               KIND_REL: begin
                  if (!ctl.lead && rel < PW'(s.n))
                     kill[k] = (ctl.b != s.pat[8*rel[3:0] +: 8]);
               end
               KIND_ABS: begin
                  if (pos >= PW'(s.off) && pos < PW'(s.off) + PW'(s.n)) begin
                     j = pos - PW'(s.off);
                     if (s.care[j[3:0]])
                        kill[k] = (ctl.b != s.pat[8*j[3:0] +: 8]);
                  end
               end
               KIND_MP4: begin
                  if (pos >= PW'(4) && pos < PW'(8)) begin
                     case (pos[1:0])
                        2'd0:    kill[k] = ctl.b != "f";
                        2'd1:    kill[k] = ctl.b != "t";
                        2'd2:    kill[k] = ctl.b != "y";
                        default: kill[k] = ctl.b != "p";
                     endcase
                  end
               end
               default: kill[k] = 1'b0;
            endcase
         end
      end
   end

endmodule

>>> src/cts_verdict.sv
// ----------------------------------------------------------------------------
// cts_verdict
// Final decision: lowest-index live rule whose condition holds, else text or none.
// ----------------------------------------------------------------------------
module cts_verdict
   import cts_pkg::*;
#(
   parameter int PW = 10
) (
   input  logic [NUM_RULES-1:0] alive,
   input  logic [PW-1:0]        len,
   input  logic [PW-1:0]        rel,
   input  logic                 mp4_ok,
   input  logic                 text_clean,
   output logic [5:0]           rule_index,
   output logic [5:0]           media_type
);

   logic [NUM_RULES-1:0] hit;

   always_comb begin
      rule_type s;
      for (int k = 0; k < NUM_RULES; k++) begin
         s = rule_at(k);
         case (s.kind)
            KIND_HTML: hit[k] = alive[k] && (rel >= PW'(s.n) + PW'(1));
            KIND_REL:  hit[k] = alive[k] && (rel >= PW'(s.n));
            KIND_ABS:  hit[k] = alive[k] && (len >= PW'(s.need));
            default:   hit[k] = alive[k] && mp4_ok;
         endcase
      end
   end

   always_comb begin
      rule_type s;
      rule_index = text_clean ? RULE_TEXT : RULE_NONE;
      media_type = text_clean ? MEDIA_TEXT : MEDIA_OCTET;
      for (int k = NUM_RULES - 1; k >= 0; k--) begin
         s = rule_at(k);
         if (hit[k]) begin
            rule_index = 6'(k);
            media_type = s.media;
         end
      end
   end

endmodule

>>> src/content_type_sniffer_core.sv
// ----------------------------------------------------------------------------
// content_type_sniffer_core
// Streams a file head byte by byte and reports its sniffed content type.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | data_byte, byte_valid, end_of_stream
//  rsp     | out       | rsp_valid/rsp_stall | rule_index, media_type
//
// One transaction per cycle while req_stall is low: each byte updates all rule
// flags in parallel in the cycle it is accepted; the verdict is formed from the
// updated flags and lands in the result register, visible from the next cycle.
// Only a final transaction produces a result; then all scan state reloads.
// req_stall is high only while a result waits and rsp_stall holds it.
// Synchronous active-high reset clears the scan state and the result valid.
`include "content_type_sniffer_core_assert.svh"
module content_type_sniffer_core
   import cts_pkg::*;
#(
   parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_byte_valid,
   input  logic       req_end_of_stream,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [5:0] rsp_rule_index,
   output logic [5:0] rsp_media_type
);

   localparam int PW = $clog2(WINDOW_BYTES + 1);

   // scan state
   logic [PW-1:0]        pos_ff, pos_in;
   logic                 lead_ff, lead_in;
   logic [PW-1:0]        lsc_ff, lsc_in;
   logic [NUM_RULES-1:0] alive_ff, alive_in;
   logic [31:0]          box_ff, box_in;
   logic                 brand_ff, brand_in;
   logic                 clean_ff, clean_in;
   logic [7:0]           h1_ff, h1_in, h2_ff, h2_in;
   // result register
   logic                 rv_ff, rv_in;
   logic [5:0]           ri_ff, ri_in, mt_ff, mt_in;

   logic                 acc;
   byte_ctl_type         ctl;
   logic [PW-1:0]        rel;
   logic [NUM_RULES-1:0] kill;
   logic [PW-1:0]        rel_fin;
   logic                 mp4_ok;
   logic [PW-1:0]        ibox;
   logic [5:0]           v_rule, v_media;

   assign req_stall = rv_ff && rsp_stall;
   assign acc       = req_valid && !req_stall;

   always_comb begin
      ctl.take = acc && req_byte_valid && (pos_ff < PW'(WINDOW_BYTES));
      ctl.b    = req_data_byte;
      ctl.lead = lead_ff && is_space(req_data_byte);
   end

   // leading whitespace run and relative offset of this byte
   assign lsc_in = (ctl.take && ctl.lead) ? lsc_ff + PW'(1) : lsc_ff;
   assign lead_in = ctl.take ? ctl.lead : lead_ff;
   assign rel = pos_ff - lsc_ff;

   cts_match #(.PW(PW)) u_match (
      .ctl  (ctl),
      .pos  (pos_ff),
      .rel  (rel),
      .kill (kill)
   );

   assign ibox = pos_ff - PW'(2);

   always_comb begin
      pos_in   = ctl.take ? pos_ff + PW'(1) : pos_ff;
      alive_in = alive_ff & ~kill;
      box_in   = box_ff;
      brand_in = brand_ff;
      clean_in = clean_ff;
      h1_in    = h1_ff;
      h2_in    = h2_ff;
      if (ctl.take) begin
         if (alive_ff[RULE_MP4] && pos_ff < PW'(4))
            box_in = {box_ff[23:0], ctl.b};
         if (alive_ff[RULE_MP4] && pos_ff >= PW'(10) && ibox[1:0] == 2'b00 &&
             ibox != PW'(12) && {{(32 - PW){1'b0}}, ibox} < box_ff &&
             h2_ff == "m" && h1_ff == "p" && ctl.b == "4")
            brand_in = 1'b1;
         if (is_control(ctl.b)) clean_in = 1'b0;
         h2_in = h1_ff;
         h1_in = ctl.b;
      end
   end

   // verdict on the updated state
   assign rel_fin = lead_in ? '0 : pos_in - lsc_in;
   assign mp4_ok = (pos_in >= PW'(12)) && (box_in <= {{(32 - PW){1'b0}}, pos_in}) &&
                   (box_in[1:0] == 2'b00) && brand_in;

   cts_verdict #(.PW(PW)) u_verdict (
      .alive      (alive_in),
      .len        (pos_in),
      .rel        (rel_fin),
      .mp4_ok     (mp4_ok),
      .text_clean (clean_in),
      .rule_index (v_rule),
      .media_type (v_media)
   );

   always_comb begin
      rv_in = rv_ff && rsp_stall;
      ri_in = ri_ff;
      mt_in = mt_ff;
      if (acc && req_end_of_stream) begin
         rv_in = 1'b1;
         ri_in = v_rule;
         mt_in = v_media;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (acc && req_end_of_stream)) begin
         pos_ff   <= '0;
         lead_ff  <= 1'b1;
         lsc_ff   <= '0;
         alive_ff <= '1;
         box_ff   <= '0;
         brand_ff <= 1'b0;
         clean_ff <= 1'b1;
         h1_ff    <= '0;
         h2_ff    <= '0;
      end else begin
         pos_ff   <= pos_in;
         lead_ff  <= lead_in;
         lsc_ff   <= lsc_in;
         alive_ff <= alive_in;
         box_ff   <= box_in;
         brand_ff <= brand_in;
         clean_ff <= clean_in;
         h1_ff    <= h1_in;
         h2_ff    <= h2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
      end
      ri_ff <= ri_in;
      mt_ff <= mt_in;
   end

   assign rsp_valid      = rv_ff;
   assign rsp_rule_index = ri_ff;
   assign rsp_media_type = mt_ff;

   `CTS_ASSERT_IMP(a_pos_window, clock, reset, 1'b1, pos_ff <= PW'(WINDOW_BYTES),
                   "byte position beyond window")
   `CTS_ASSERT_IMP(a_lsc_le_pos, clock, reset, 1'b1, lsc_ff <= pos_ff,
                   "leading space count exceeds position")
   `CTS_ASSERT_NEXT(a_eos_result, clock, reset, acc && req_end_of_stream, rsp_valid,
                    "final transaction gave no result")
   `CTS_ASSERT_NEXT(a_eos_clear, clock, reset, acc && req_end_of_stream,
                    pos_ff == '0 && alive_ff == '1, "scan state not reloaded")
   `CTS_ASSERT_IMP(a_text_code, clock, reset, rsp_valid && rsp_rule_index == RULE_TEXT,
                   rsp_media_type == MEDIA_TEXT, "plain text code mismatch")

endmodule
